// ===== design/bfdh_pkg.sv =====
// bfdh_pkg: shared types, constants and helper functions of the bloom filter block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bfdh_pkg;

    // key hash and store geometry
    localparam int HASH_W     = 32;
    localparam int MAX_BITS   = 4096;
    localparam int MAX_PROBES = 30;
    localparam int MIN_BITS   = 64;
    localparam int ROT_RIGHT  = 17;

    localparam int POS_W  = $clog2(MAX_BITS);
    localparam int NB_W   = POS_W + 1;
    localparam int ROW_BITS = 16;
    localparam int ROW_W  = $clog2(ROW_BITS);
    localparam int ROWS   = MAX_BITS / ROW_BITS;
    localparam int ADDR_W = $clog2(ROWS);
    localparam int K_W    = $clog2(MAX_PROBES + 1);

    // configuration registers
    localparam int HC_W      = 5;
    localparam int FB_W      = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = 2'd1;
    localparam logic [HC_W-1:0] HC_RESET = 5'd6;
    localparam logic [FB_W-1:0] FB_RESET = 13'd4096;

    // operation codes
    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    // remainder unit: bits retired per cycle
    localparam int MOD_STEP  = 4;
    localparam int MOD_CYC   = HASH_W / MOD_STEP;
    localparam int MOD_CNT_W = $clog2(MOD_CYC);

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [HASH_W-1:0] key_hash;
    } req_t;

    typedef struct packed {
        logic              may_match;
        logic [FUNC_W-1:0] op_echo;
    } rsp_t;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_INSERT,
        K_QUERY,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [FUNC_W-1:0] func;
        logic [HASH_W-1:0] key_hash;
        logic [HASH_W-1:0] delta;
    } cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] r_h;
        logic [POS_W-1:0] r_d;
        logic [POS_W-1:0] r_t;
    } mod_res_t;

    // probe step: hash rotated right
    function automatic logic [HASH_W-1:0] rotr_hash(input logic [HASH_W-1:0] h);
        return (h >> ROT_RIGHT) | (h << (HASH_W - ROT_RIGHT));
    endfunction

    // store size in use: round up to eight, clamp to legal range
    function automatic logic [NB_W-1:0] eff_bits(input logic [FB_W-1:0] fb);
        logic [31:0] b;
        b = (32'(fb) + 32'd7) & ~32'd7;
        if (b < 32'(MIN_BITS))
            b = 32'(MIN_BITS);
        if (b > 32'(MAX_BITS))
            b = 32'(MAX_BITS);
        return b[NB_W-1:0];
    endfunction

    // probe count in use: clamp to one .. max probes
    function automatic logic [K_W-1:0] eff_probes(input logic [HC_W-1:0] hc);
        logic [31:0] k;
        k = 32'(hc);
        if (k < 32'd1)
            k = 32'd1;
        if (k > 32'(MAX_PROBES))
            k = 32'(MAX_PROBES);
        return k[K_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/bloom_filter_double_hash.sv =====
// bloom_filter_double_hash: top level, config registers and the front / queue / back chain
// depends on bfdh_pkg, bfdh_front, bfdh_queue, bfdh_back
`timescale 1ns / 1ps
`default_nettype none

// bloom filter over a 4096-bit store with double hashing. each req item carries
// an operation (clear, insert, query) and a precomputed 32-bit key hash; each item
// gives exactly one rsp item with may_match and the echoed operation code.
// a clear or an unknown operation passes the front stage register, the queue and
// the back end, whose done state loads the result register.
// insert and query pass through the front stage and the queue, then the remainder unit
// (8 steps of 4 quotient bits, three lanes in parallel giving hash mod n, step mod n
// and the 2^32 wrap term), then a read and a write-back state per probe on the
// single-port row memory, and last the done state that loads the result register.
// the back end takes no new item until it is back in idle, that is after the
// result of its current item is loaded into the result register.
// a query stops at its first clear probe bit. the front stage and a two-deep
// command queue keep taking items while the back end works, and the result
// register holds a finished item until it is taken.
// the store is 256 rows of 16 bits, each row with a valid flop that reset and
// clear drop all together, so there is no clearing pass after reset.
// config writes (hash_count at index 0, filter_bits at index 1) take effect at once
// and must only be made while no item is in flight; other indexes are ignored.

module bloom_filter_double_hash (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire bfdh_pkg::req_t                req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output bfdh_pkg::rsp_t                     rsp,
    input  wire logic                          cfg_we,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [bfdh_pkg::CFG_W-1:0]     cfg_wdata
);
    import bfdh_pkg::*;

    // configuration registers
    logic [HC_W-1:0] hash_count_reg;
    logic [HC_W-1:0] hash_count_next;
    logic [FB_W-1:0] filter_bits_reg;
    logic [FB_W-1:0] filter_bits_next;

    // front to queue
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // queue to back
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    always_comb
    begin
        hash_count_next  = hash_count_reg;
        filter_bits_next = filter_bits_reg;
        if (cfg_we)
        begin
            if (cfg_idx == REG_HASH_COUNT)
                hash_count_next = cfg_wdata[HC_W-1:0];
            else if (cfg_idx == REG_FILTER_BITS)
                filter_bits_next = cfg_wdata[FB_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_count_reg  <= HC_RESET;
            filter_bits_reg <= FB_RESET;
        end
        else
        begin
            hash_count_reg  <= hash_count_next;
            filter_bits_reg <= filter_bits_next;
        end
    end

    // input stage: take item, decode operation, form probe step
    bfdh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // decouples the front from the probe sequencer
    bfdh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push       (cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop        (q_cmd)
    );

    // probe sequencer, store and result register
    bfdh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd         (q_cmd),
        .hash_count  (hash_count_reg),
        .filter_bits (filter_bits_reg),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

// ===== design/bfdh_front.sv =====
// bfdh_front: input stage, takes items and classifies them into commands
// depends on bfdh_pkg
`timescale 1ns / 1ps
`default_nettype none

module bfdh_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire bfdh_pkg::req_t req,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output bfdh_pkg::cmd_t     cmd
);
    import bfdh_pkg::*;

    logic  cmd_valid_reg;
    logic  cmd_valid_next;
    cmd_t  cmd_reg;
    cmd_t  cmd_next;
    kind_t kind;

    always_comb
    begin
        unique case (req.func)
            FUNC_CLEAR:  kind = K_CLEAR;
            FUNC_INSERT: kind = K_INSERT;
            FUNC_QUERY:  kind = K_QUERY;
            default:     kind = K_NOP;
        endcase
    end

    assign req_ready = !cmd_valid_reg || cmd_ready;

    always_comb
    begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        if (cmd_valid_reg && cmd_ready)
            cmd_valid_next = 1'b0;
        if (req_valid && req_ready)
        begin
            cmd_valid_next    = 1'b1;
            cmd_next.kind     = kind;
            cmd_next.func     = req.func;
            cmd_next.key_hash = req.key_hash;
            cmd_next.delta    = rotr_hash(req.key_hash);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= cmd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

// ===== design/bfdh_queue.sv =====
// bfdh_queue: short command queue between front and back
// depends on bfdh_pkg
`timescale 1ns / 1ps
`default_nettype none

module bfdh_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire bfdh_pkg::cmd_t push,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output bfdh_pkg::cmd_t      pop
);
    import bfdh_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg < Q_CNT_W'(Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop        = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push;
    end

endmodule

`default_nettype wire

// ===== design/bfdh_mod.sv =====
// bfdh_mod: multi-cycle remainder unit, three lanes sharing one divisor
// lanes: key hash, probe step, all-ones word (for the 2^32 wrap term); depends on bfdh_pkg
`timescale 1ns / 1ps
`default_nettype none

module bfdh_mod (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bfdh_pkg::HASH_W-1:0] hash,
    input  wire logic [bfdh_pkg::HASH_W-1:0] delta,
    input  wire logic [bfdh_pkg::NB_W-1:0]   nbits,
    output logic                           done,
    output bfdh_pkg::mod_res_t             res
);
    import bfdh_pkg::*;

    localparam int LANES = 3;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_CNT_W-1:0] cnt_next;
    logic [HASH_W-1:0]    sh_reg   [LANES];
    logic [HASH_W-1:0]    sh_next  [LANES];
    logic [POS_W-1:0]     rem_reg  [LANES];
    logic [POS_W-1:0]     rem_next [LANES];

    // restoring division steps per lane, MOD_STEP of them at a time
    always_comb
    begin
        logic [POS_W-1:0]  r;
        logic [HASH_W-1:0] s;
        logic [NB_W-1:0]   t;
        for (int l = 0; l < LANES; l++)
        begin
            r = rem_reg[l];
            s = sh_reg[l];
            for (int st = 0; st < MOD_STEP; st++)
            begin
                t = {r, s[HASH_W-1]};
                s = s << 1;
                if (t >= nbits)
                    t = t - nbits;
                r = t[POS_W-1:0];
            end
            rem_next[l] = r;
            sh_next[l]  = s;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + MOD_CNT_W'(1);
            if (cnt_reg == MOD_CNT_W'(MOD_CYC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg[0]  <= hash;
            sh_reg[1]  <= delta;
            sh_reg[2]  <= '1;
            rem_reg[0] <= '0;
            rem_reg[1] <= '0;
            rem_reg[2] <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign done    = done_reg;
    assign res.r_h = rem_reg[0];
    assign res.r_d = rem_reg[1];
    assign res.r_t = rem_reg[2];

endmodule

`default_nettype wire

// ===== design/bfdh_back.sv =====
// bfdh_back: probe sequencer, bit store with row valid bits, result register
// depends on bfdh_pkg and bfdh_mod
`timescale 1ns / 1ps
`default_nettype none

module bfdh_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cmd_valid,
    output logic                         cmd_ready,
    input  wire bfdh_pkg::cmd_t          cmd,
    input  wire logic [bfdh_pkg::HC_W-1:0] hash_count,
    input  wire logic [bfdh_pkg::FB_W-1:0] filter_bits,
    output logic                         rsp_valid,
    input  wire logic                    rsp_ready,
    output bfdh_pkg::rsp_t               rsp
);
    import bfdh_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [HASH_W-1:0] delta_reg, delta_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  d_reg, d_next;
    logic [POS_W-1:0]  c_reg, c_next;
    logic [K_W-1:0]    cnt_reg, cnt_next;
    logic              match_reg, match_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic [NB_W-1:0]   nbits;
    logic [K_W-1:0]    kprobes;
    logic              mod_start;
    logic              mod_done;
    mod_res_t          mod_res;
    logic [NB_W-1:0]   wrap_inc;
    logic [POS_W-1:0]  c_val;

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROWS-1:0]     row_valid_reg;
    logic [ROW_BITS-1:0] rdata_reg;
    logic                rvalid_reg;
    logic                mem_re;
    logic                mem_we;
    logic                clear_all;
    logic [ADDR_W-1:0]   addr;
    logic [ROW_BITS-1:0] row_cur;
    logic [ROW_BITS-1:0] wdata;
    logic                probe_bit;

    logic [HASH_W:0]     hsum;
    logic [NB_W-1:0]     s1;
    logic [POS_W-1:0]    p1;
    logic [NB_W-1:0]     s2;
    logic [POS_W-1:0]    pos_adv;

    assign nbits   = eff_bits(filter_bits);
    assign kprobes = eff_probes(hash_count);

    bfdh_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .hash  (cmd.key_hash),
        .delta (cmd.delta),
        .nbits (nbits),
        .done  (mod_done),
        .res   (mod_res)
    );

    // 2^32 mod n from (2^32 - 1) mod n
    assign wrap_inc = {1'b0, mod_res.r_t} + NB_W'(1);
    assign c_val    = (wrap_inc == nbits) ? '0 : wrap_inc[POS_W-1:0];

    // row access
    assign addr      = pos_reg[POS_W-1:ROW_W];
    assign row_cur   = rvalid_reg ? rdata_reg : '0;
    assign probe_bit = row_cur[pos_reg[ROW_W-1:0]];
    assign wdata     = row_cur | (ROW_BITS'(1) << pos_reg[ROW_W-1:0]);

    // next probe position kept mod n, with correction on 32-bit wrap
    always_comb
    begin
        hsum = {1'b0, h_reg} + {1'b0, delta_reg};
        s1   = {1'b0, pos_reg} + {1'b0, d_reg};
        p1   = (s1 >= nbits) ? POS_W'(s1 - nbits) : s1[POS_W-1:0];
        s2   = {1'b0, p1} + nbits - {1'b0, c_reg};
        if (!hsum[HASH_W])
            pos_adv = p1;
        else if (p1 >= c_reg)
            pos_adv = p1 - c_reg;
        else
            pos_adv = s2[POS_W-1:0];
    end

    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        func_next   = func_reg;
        h_next      = h_reg;
        delta_next  = delta_reg;
        pos_next    = pos_reg;
        d_next      = d_reg;
        c_next      = c_reg;
        cnt_next    = cnt_reg;
        match_next  = match_reg;
        rsp_next    = rsp_reg;
        mod_start   = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        clear_all   = 1'b0;
        rsp_valid_next = (rsp_valid_reg && rsp_ready) ? 1'b0 : rsp_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    kind_next  = cmd.kind;
                    func_next  = cmd.func;
                    h_next     = cmd.key_hash;
                    delta_next = cmd.delta;
                    match_next = 1'b0;
                    unique case (cmd.kind)
                        K_CLEAR:
                        begin
                            clear_all  = 1'b1;
                            state_next = ST_DONE;
                        end
                        K_INSERT, K_QUERY:
                        begin
                            mod_start  = 1'b1;
                            state_next = ST_MOD;
                        end
                        K_NOP:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    pos_next   = mod_res.r_h;
                    d_next     = mod_res.r_d;
                    c_next     = c_val;
                    cnt_next   = '0;
                    match_next = (kind_reg == K_QUERY);
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                mem_we = (kind_reg == K_INSERT);
                priority if (kind_reg == K_QUERY && !probe_bit)
                begin
                    match_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if (cnt_reg == K_W'(kprobes - K_W'(1)))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + K_W'(1);
                    h_next     = hsum[HASH_W-1:0];
                    pos_next   = pos_adv;
                    state_next = ST_RD;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.may_match = match_reg;
                    rsp_next.op_echo   = func_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (clear_all)
                row_valid_reg <= '0;
            else if (mem_we)
                row_valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        func_reg  <= func_next;
        h_reg     <= h_next;
        delta_reg <= delta_next;
        pos_reg   <= pos_next;
        d_reg     <= d_next;
        c_reg     <= c_next;
        cnt_reg   <= cnt_next;
        match_reg <= match_next;
        rsp_reg   <= rsp_next;
    end

    // bit store, one row per access
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr] <= wdata;
        if (mem_re)
        begin
            rdata_reg  <= mem[addr];
            rvalid_reg <= row_valid_reg[addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== design/bfdh_chk.sv =====
// bfdh_chk: port-level checks on the bloom filter top level
// depends on bfdh_pkg; attached to bloom_filter_double_hash by the bind below
`timescale 1ns / 1ps
`default_nettype none

module bfdh_chk (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic                          req_ready,
    input  wire bfdh_pkg::req_t                req,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire bfdh_pkg::rsp_t                rsp,
    input  wire logic                          cfg_we,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [bfdh_pkg::CFG_W-1:0]     cfg_wdata
);
    import bfdh_pkg::*;

    // a waiting result stays put until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed or dropped while stalled");

    // only a query can report a possible match
    a_match_query: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.may_match |-> rsp.op_echo == FUNC_QUERY)
        else $error("may_match set on a non-query result");

    // input side closes only right after taking an item
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(req_valid && req_ready))
        else $error("req_ready fell without an accepted item");

endmodule

bind bloom_filter_double_hash bfdh_chk u_chk (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: self-checking bench for bloom_filter_double_hash, directed table then random phases
// depends on bfdh_pkg and the bloom_filter_double_hash rtl
`timescale 1ns / 1ps

module testbench;
    import bfdh_pkg::*;

    // codes with no name in the package
    localparam logic [FUNC_W-1:0]    FUNC_UNKNOWN    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;   // quiet cycles before giving up
    localparam int LONG_HOLD      = 300;    // receiver hold-off that backs up the input
    localparam int DRAIN_TAIL     = 80;     // about one slow item of latency
    localparam int PHASE_ITEMS    = 140;

    // one row of the directed table; known marks rows whose answer is typed in
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [HASH_W-1:0] key;
        logic              known;
        logic              match;
    } dir_row_t;

    localparam int DIR_ROWS = 22;
    localparam dir_row_t DIRECTED_ROWS [0:DIR_ROWS-1] = '{
        '{FUNC_QUERY,   32'h0000_0000, 1'b1, 1'b0},  // empty store answers absent
        '{FUNC_QUERY,   32'hFFFF_FFFF, 1'b1, 1'b0},
        '{FUNC_UNKNOWN, 32'h1234_5678, 1'b1, 1'b0},  // unknown op is a no-op
        '{FUNC_INSERT,  32'h0000_0000, 1'b1, 1'b0},  // zero hash: every probe is bit 0
        '{FUNC_QUERY,   32'h0000_0000, 1'b1, 1'b1},
        '{FUNC_INSERT,  32'hFFFF_FFFF, 1'b1, 1'b0},
        '{FUNC_QUERY,   32'hFFFF_FFFF, 1'b1, 1'b1},
        '{FUNC_QUERY,   32'h8000_0000, 1'b0, 1'b0},
        '{FUNC_INSERT,  32'h0000_0001, 1'b1, 1'b0},
        '{FUNC_QUERY,   32'h0000_0001, 1'b1, 1'b1},
        '{FUNC_INSERT,  32'h0001_0000, 1'b1, 1'b0},
        '{FUNC_QUERY,   32'h0002_0000, 1'b0, 1'b0},
        '{FUNC_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{FUNC_QUERY,   32'hDEAD_BEEF, 1'b0, 1'b0},
        '{FUNC_CLEAR,   32'hFFFF_FFFF, 1'b1, 1'b0},  // clear ignores the hash
        '{FUNC_QUERY,   32'h0000_0000, 1'b1, 1'b0},
        '{FUNC_QUERY,   32'hFFFF_FFFF, 1'b1, 1'b0},
        '{FUNC_INSERT,  32'hA5A5_A5A5, 1'b1, 1'b0},
        '{FUNC_QUERY,   32'h5A5A_5A5A, 1'b0, 1'b0},
        '{FUNC_QUERY,   32'hA5A5_A5A5, 1'b1, 1'b1},
        '{FUNC_CLEAR,   32'h0000_0000, 1'b1, 1'b0},
        '{FUNC_QUERY,   32'hA5A5_A5A5, 1'b1, 1'b0}
    };

    // register settings per random phase, extremes and out-of-range values included
    typedef struct packed {
        logic [HC_W-1:0] hc;
        logic [FB_W-1:0] fb;
    } setting_t;

    localparam int PHASES       = 8;
    localparam int RANDOM_PHASE = 6;   // this one draws its settings at run time
    localparam int HOLD_PHASE   = 1;   // this one gets the long receiver hold-off
    localparam setting_t PHASE_SETTINGS [0:PHASES-1] = '{
        '{5'd1,  13'd64},     // smallest legal setting
        '{5'd30, 13'd4096},   // largest legal setting
        '{5'd0,  13'd0},      // both clamp upward
        '{5'd31, 13'd8191},   // both clamp downward
        '{5'd3,  13'd65},     // rounds up to 72
        '{5'd17, 13'd4095},   // rounds up to the full store
        '{5'd0,  13'd0},
        '{5'd6,  13'd1000}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    logic cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    req_t req = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;

    bloom_filter_double_hash dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // shadow copy of the filter: store bits and the two registers
    logic [MAX_BITS-1:0] bloom_bits = '0;
    logic [HC_W-1:0]     probe_reg  = 5'd6;
    logic [FB_W-1:0]     size_reg   = 13'd4096;

    rsp_t pending_answers [$];      // answers owed by the block, oldest first
    logic [HASH_W-1:0] live_keys [$];  // keys inserted since the last clear
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    bit sender_idle   = 1'b1;
    bit receiver_idle = 1'b1;
    bit long_hold_req = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // store bits in use: round up to a byte, then hold to the legal range
    function automatic int unsigned bits_in_use();
        int unsigned n;
        n = (int'(size_reg) + 7) & ~32'd7;
        if (n < MIN_BITS)
            n = MIN_BITS;
        if (n > MAX_BITS)
            n = MAX_BITS;
        return n;
    endfunction

    function automatic int unsigned probes_in_use();
        int unsigned k;
        k = probe_reg;
        if (k == 0)
            k = 1;
        if (k > MAX_PROBES)
            k = MAX_PROBES;
        return k;
    endfunction

    // computes the answer to one item and applies its effect to the shadow store
    function automatic rsp_t predict_answer(input req_t it);
        logic [31:0] h;
        logic [31:0] step;
        logic [31:0] pos;
        int unsigned n;
        int unsigned k;
        rsp_t ans;
        n = bits_in_use();
        k = probes_in_use();
        h = it.key_hash;
        step = {h[16:0], h[31:17]};     // hash rotated right by 17
        ans.may_match = 1'b0;
        ans.op_echo = it.func;
        case (it.func)
            FUNC_CLEAR:
                bloom_bits = '0;
            FUNC_INSERT:
                for (int j = 0; j < k; j++)
                begin
                    pos = h % n;
                    bloom_bits[pos] = 1'b1;
                    h = h + step;
                end
            FUNC_QUERY:
            begin
                ans.may_match = 1'b1;
                // first clear probe bit rules the key out
                for (int j = 0; j < k; j++)
                begin
                    pos = h % n;
                    if (!bloom_bits[pos])
                    begin
                        ans.may_match = 1'b0;
                        break;
                    end
                    h = h + step;
                end
            end
            default:
                ;   // unknown op leaves the store alone
        endcase
        return ans;
    endfunction

    // offers one item, holding valid until taken; typed answers override the predictor
    task automatic offer(input req_t it, input logic known, input logic match);
        int unsigned gap;
        rsp_t ans;
        gap = 0;
        if (sender_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        ans = predict_answer(it);
        if (known)
        begin
            ans.may_match = match;
            ans.op_echo = it.func;
        end
        pending_answers = {pending_answers, ans};
    endtask

    // register write; the caller lowers cfg_we after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx == REG_HASH_COUNT)
            probe_reg = data[HC_W-1:0];
        else if (idx == REG_FILTER_BITS)
            size_reg = data[FB_W-1:0];
    endtask

    // random item: mostly inserts and queries, queries often on keys already inserted
    function automatic req_t random_item();
        req_t it;
        int unsigned pick;
        logic [31:0] key;
        pick = $urandom_range(0, 99);
        key = $urandom();
        if (pick < 3)
        begin
            it.func = FUNC_CLEAR;
            live_keys.delete();
        end
        else if (pick < 6)
            it.func = FUNC_UNKNOWN;
        else if (pick < 50)
        begin
            it.func = FUNC_INSERT;
            live_keys = {live_keys, key};
            if (live_keys.size() > 64)
                void'(live_keys.pop_front());
        end
        else
        begin
            it.func = FUNC_QUERY;
            if (live_keys.size() != 0 && $urandom_range(0, 1) == 1)
            begin
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
                // near miss: same key with one bit flipped
                if ($urandom_range(0, 3) == 0)
                    key[$urandom_range(0, 31)] ^= 1'b1;
            end
        end
        it.key_hash = key;
        return it;
    endfunction

    // receiver: takes results, stalls in bursts, and once holds off for a long stretch
    initial
    begin
        int unsigned stall_left;
        rsp_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch($sformatf("unexpected result match %0b op %0d",
                                              rsp.may_match, rsp.op_echo));
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp.may_match !== want.may_match)
                        report_mismatch($sformatf("may_match %0b, wanted %0b (op %0d)",
                                                  rsp.may_match, want.may_match, want.op_echo));
                    if (rsp.op_echo !== want.op_echo)
                        report_mismatch($sformatf("op_echo %0d, wanted %0d",
                                                  rsp.op_echo, want.op_echo));
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                rsp_ready <= 1'b0;
            end
            else if (receiver_idle && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // watchdog: any handshake or register write counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
            || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d answers owed",
                     quiet_cycles, pending_answers.size());
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // main sequence
    initial
    begin
        req_t it;
        setting_t s;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset settings
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            it.func = DIRECTED_ROWS[i].func;
            it.key_hash = DIRECTED_ROWS[i].key;
            offer(it, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].match);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            // registers change only once the block has nothing in flight
            req_valid <= 1'b0;
            while (pending_answers.size() != 0)
                @(posedge clk);
            s = PHASE_SETTINGS[p];
            if (p == RANDOM_PHASE)
            begin
                s.hc = HC_W'($urandom_range(1, MAX_PROBES));
                s.fb = FB_W'($urandom_range(MIN_BITS / 8, MAX_BITS / 8) * 8);
            end
            // upper data bits ride along on the narrow register and must be dropped
            write_reg(REG_HASH_COUNT, {8'($urandom()), s.hc});
            write_reg(REG_FILTER_BITS, s.fb);
            if (p == 2 || p == RANDOM_PHASE)
            begin
                // writes to unmapped indexes must not disturb anything
                write_reg(REG_UNMAPPED_LO, CFG_W'($urandom()));
                write_reg(REG_UNMAPPED_HI, CFG_W'($urandom()));
            end
            cfg_we <= 1'b0;

            // stretches with no idling: one phase in the middle and the closing one
            sender_idle = (p != 3 && p != PHASES - 1);
            receiver_idle = sender_idle;
            if (p == HOLD_PHASE)
                long_hold_req = 1'b1;

            for (int i = 0; i < PHASE_ITEMS; i++)
                offer(random_item(), 1'b0, 1'b0);
        end

        req_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        // catch any stray result after the last one owed
        repeat (DRAIN_TAIL) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bfdh_pkg.sv
design/bfdh_front.sv
design/bfdh_queue.sv
design/bfdh_mod.sv
design/bfdh_back.sv
design/bloom_filter_double_hash.sv
design/bfdh_chk.sv
sim/testbench.sv
